// ===== rtl/nlse_pkg.sv =====
// ============================================================================
// nlse_pkg: shared constants and tables for the log-sum-exp wirelength block
// Fixed-point constants, code values and the square-root chain of 2^-2^-i.
// ============================================================================
package nlse_pkg;

    localparam int COORD_FRAC_BITS_DEF = 12;
    localparam int SUM_INT_BITS_DEF    = 16;
    localparam int FUNC_ITERATIONS_DEF = 16;

    localparam int ROOT_COUNT = 32;
    localparam int QUO_W      = 22;
    localparam int LEN_W      = 40;
    localparam int TOT_W      = 56;
    localparam int LEN_ACC_W  = 48;

    localparam logic [QUO_W-1:0] T_CAP     = 22'h20_0000;
    localparam logic [30:0]      LOG2E_Q30 = 31'h5C55_1D95;
    localparam logic [31:0]      LN2_Q32   = 32'hB172_17F8;
    localparam logic [31:0]      ALPHA_RESET = 32'd655360;
    localparam logic [LEN_W-1:0] LEN_MAX   = 40'hFF_FFFF_FFFF;
    localparam logic [TOT_W-1:0] TOTAL_MAX = 56'hFF_FFFF_FFFF_FFFF;

    // register index of the alpha register on the configuration port
    localparam logic REG_ALPHA = 1'b0;

    typedef logic [31:0] root_tab_t [ROOT_COUNT];

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bval;
        n    = n_in;
        res  = '0;
        bval = 64'h4000_0000_0000_0000;
        for (int j = 0; j < 32; j++) begin
            if (bval > n) begin
                bval = bval >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (bval != 0) begin
                if (n >= res + bval) begin
                    n   = n - (res + bval);
                    res = (res >> 1) + bval;
                end
                else begin
                    res = res >> 1;
                end
                bval = bval >> 2;
            end
        end
        return res;
    endfunction

    function automatic root_tab_t make_roots();
        root_tab_t   r;
        logic [63:0] v;
        v    = isqrt64(64'h8000_0000_0000_0000);
        r[0] = v[31:0];
        for (int i = 1; i < ROOT_COUNT; i++) begin
            v    = isqrt64({r[i-1], 32'h0});
            r[i] = v[31:0];
        end
        return r;
    endfunction

    // root i is 2^(-2^-(i+1)) in Q.32, floor square-root chain
    localparam root_tab_t ROOTS = make_roots();

endpackage

// ===== rtl/nlse_div.sv =====
// ============================================================================
// nlse_div: bit-serial divider for the exponent argument
// Forms min(floor(diff * 2^(32-CF) / divisor), 32.0 in Q16.16), one bit a cycle.
// ============================================================================
module nlse_div
    import nlse_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [31:0]      diff,
    input  logic [31:0]      divisor,
    output logic             done,
    output logic [QUO_W-1:0] quo
);

    localparam int SHIFT_S = 32 - COORD_FRAC_BITS;
    localparam int DW      = 32 + SHIFT_S;
    localparam int HW      = DW - QUO_W;
    localparam int CNT_W   = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(QUO_W - 1);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} div_state_t;

    div_state_t       state_reg;
    logic [31:0]      rem_reg;
    logic [QUO_W-1:0] low_reg;
    logic [QUO_W-1:0] q_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [DW-1:0]    dividend;
    logic [HW-1:0]    hi_part;
    logic             over;
    logic [32:0]      rem_sh;
    logic             qbit;

    always_comb begin
        dividend = {diff, {SHIFT_S{1'b0}}};
        hi_part  = dividend[DW-1:QUO_W];
        over     = 64'(hi_part) >= 64'(divisor);
        rem_sh   = {rem_reg, low_reg[QUO_W-1]};
        qbit     = rem_sh >= 33'(divisor);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= D_IDLE;
            rem_reg   <= '0;
            low_reg   <= '0;
            q_reg     <= '0;
            cnt_reg   <= '0;
        end
        else begin
            unique case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        if (over) begin
                            q_reg     <= T_CAP;
                            state_reg <= D_DONE;
                        end
                        else begin
                            rem_reg   <= 32'(hi_part);
                            low_reg   <= dividend[QUO_W-1:0];
                            q_reg     <= '0;
                            cnt_reg   <= '0;
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    rem_reg <= qbit ? 32'(rem_sh - 33'(divisor)) : rem_sh[31:0];
                    low_reg <= low_reg << 1;
                    q_reg   <= {q_reg[QUO_W-2:0], qbit};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_CNT) begin
                        state_reg <= D_DONE;
                    end
                end
                D_DONE: begin
                    state_reg <= D_IDLE;
                end
                default: begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done = (state_reg == D_DONE);
    assign quo  = q_reg[QUO_W-1] ? T_CAP : q_reg;

endmodule

// ===== rtl/net_log_sum_exp_wirelength.sv =====
// ============================================================================
// net_log_sum_exp_wirelength: smoothed net wirelength with weighted total
// Pins stream in one per transaction; the last pin of a net yields one result.
// ============================================================================
// For every pin after the first of a net, each of the four directions runs
// the 22-step serial divider and FUNC_ITERATIONS steps of the shared
// multiplier; the first pin of a net only seeds the maxima and sums. A last
// pin then forms the logarithms (leading-one shift, squarings, scaling by
// alpha) and the weighting, all through the same 33x33 multiplier, and may
// wait for the output register. in_stall is high from the accepted pin until
// the block returns to idle; a finished result waits in the output register.
module net_log_sum_exp_wirelength
    import nlse_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
    parameter int SUM_INT_BITS    = SUM_INT_BITS_DEF,
    parameter int FUNC_ITERATIONS = FUNC_ITERATIONS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [31:0]      pin_x,
    input  logic signed [31:0]      pin_y,
    input  logic [15:0]             net_weight,
    input  logic                    last_pin,
    input  logic                    first_net,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [LEN_W-1:0]        net_length,
    output logic [TOT_W-1:0]        weighted_total,
    output logic                    saturated
);

    localparam int FBITS      = 32 - SUM_INT_BITS;
    localparam logic [31:0] SUM_ONE = 32'(64'd1 << FBITS);
    localparam int IT_W       = $clog2(FUNC_ITERATIONS + 1);
    localparam logic [IT_W-1:0] LAST_IT = IT_W'(FUNC_ITERATIONS - 1);
    localparam int FRAC_ALIGN = 32 - FUNC_ITERATIONS;
    localparam int LSH        = (COORD_FRAC_BITS >= 16) ? COORD_FRAC_BITS - 16 : 0;
    localparam int RSH        = (COORD_FRAC_BITS >= 16) ? 0 : 16 - COORD_FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_FOLD, S_DIV, S_UMUL, S_EXP, S_ESHIFT, S_RESCALE, S_FADD,
        S_LN_START, S_NORM, S_SQ, S_LN_F, S_LN_I, S_LN_AL, S_LN_AH, S_LN_ADD,
        S_CLAMP, S_W_LO, S_W_HI, S_TOTAL
    } state_t;

    state_t                 state_reg;
    logic [31:0]            alpha_reg;
    logic signed [31:0]     v_reg [4];
    logic [15:0]            w_reg;
    logic                   last_reg;
    logic                   first_reg;
    logic signed [31:0]     dir_max_reg [4];
    logic [31:0]            dir_sum_reg [4];
    logic                   net_open_reg;
    logic [TOT_W-1:0]       total_reg;
    logic                   sat_flag_reg;
    logic [1:0]             dir_reg;
    logic                   gt_reg;
    logic [QUO_W-1:0]       t_reg;
    logic [6:0]             k_reg;
    logic [31:0]            f_reg;
    logic [32:0]            val_reg;
    logic [IT_W-1:0]        it_reg;
    logic [31:0]            base_reg;
    logic [32:0]            add_reg;
    logic [31:0]            m_reg;
    logic [4:0]             p_reg;
    logic [31:0]            frac_reg;
    logic [31:0]            t1_reg;
    logic [37:0]            lnv_reg;
    logic [38:0]            q16_reg;
    logic signed [LEN_ACC_W-1:0] len_reg;
    logic [LEN_W-1:0]       ulen_reg;
    logic [TOT_W-1:0]       wp_reg;
    logic                   sat_res_reg;
    logic                   out_valid_reg;
    logic [LEN_W-1:0]       out_len_reg;
    logic [TOT_W-1:0]       out_tot_reg;
    logic                   out_sat_reg;

    logic [31:0]            alpha_eff;
    logic signed [31:0]     v_cur;
    logic signed [31:0]     max_cur;
    logic                   fold_gt;
    logic [32:0]            diff_w;
    logic                   div_start;
    logic                   div_done;
    logic [QUO_W-1:0]       div_quo;
    logic [32:0]            mul_a;
    logic [32:0]            mul_b;
    logic [65:0]            mul_p;
    logic [4:0]             root_idx;
    logic [32:0]            e_val;
    logic [33:0]            fold_sum;
    logic [32:0]            sq_val;
    logic [LEN_ACC_W-1:0]   ln_term;
    logic [TOT_W:0]         tot_sum;
    logic                   out_free;
    logic                   in_take;

    always_comb begin
        alpha_eff = (alpha_reg == '0) ? 32'd1 : alpha_reg;
        v_cur     = v_reg[dir_reg];
        max_cur   = dir_max_reg[dir_reg];
        fold_gt   = v_cur > max_cur;
        diff_w    = fold_gt ? 33'({v_cur[31], v_cur} - {max_cur[31], max_cur})
                            : 33'({max_cur[31], max_cur} - {v_cur[31], v_cur});
        div_start = (state_reg == S_FOLD) && net_open_reg;
        root_idx  = 5'(it_reg);
        e_val     = val_reg >> k_reg;
        fold_sum  = 34'(base_reg) + 34'(add_reg);
        sq_val    = mul_p[63:31];
        ln_term   = (LEN_ACC_W'(q16_reg) << LSH) >> RSH;
        tot_sum   = (first_reg ? '0 : {1'b0, total_reg}) + (TOT_W+1)'(wp_reg >> 8);
        out_free  = !out_valid_reg || !out_stall;
        in_take   = in_valid && !in_stall;
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_UMUL: begin
                mul_a = 33'(t_reg);
                mul_b = 33'(LOG2E_Q30);
            end
            S_EXP: begin
                mul_a = val_reg;
                mul_b = 33'(ROOTS[root_idx]);
            end
            S_RESCALE: begin
                mul_a = 33'(dir_sum_reg[dir_reg]);
                mul_b = val_reg;
            end
            S_SQ: begin
                mul_a = 33'(m_reg);
                mul_b = 33'(m_reg);
            end
            S_LN_F: begin
                mul_a = 33'(frac_reg << FRAC_ALIGN);
                mul_b = 33'(LN2_Q32);
            end
            S_LN_I: begin
                mul_a = 33'(5'(p_reg - 5'(FBITS)));
                mul_b = 33'(LN2_Q32);
            end
            S_LN_AL: begin
                mul_a = 33'(alpha_eff);
                mul_b = 33'(lnv_reg[31:0]);
            end
            S_LN_AH: begin
                mul_a = 33'(alpha_eff);
                mul_b = 33'(lnv_reg[37:32]);
            end
            S_W_LO: begin
                mul_a = 33'(w_reg);
                mul_b = 33'(ulen_reg[19:0]);
            end
            S_W_HI: begin
                mul_a = 33'(w_reg);
                mul_b = 33'(ulen_reg[39:20]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    nlse_div #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .diff   (diff_w[31:0]),
        .divisor(alpha_eff),
        .done   (div_done),
        .quo    (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            alpha_reg     <= ALPHA_RESET;
            v_reg         <= '{default: '0};
            w_reg         <= '0;
            last_reg      <= 1'b0;
            first_reg     <= 1'b0;
            dir_max_reg   <= '{default: '0};
            dir_sum_reg   <= '{default: '0};
            net_open_reg  <= 1'b0;
            total_reg     <= '0;
            sat_flag_reg  <= 1'b0;
            dir_reg       <= '0;
            gt_reg        <= 1'b0;
            t_reg         <= '0;
            k_reg         <= '0;
            f_reg         <= '0;
            val_reg       <= '0;
            it_reg        <= '0;
            base_reg      <= '0;
            add_reg       <= '0;
            m_reg         <= '0;
            p_reg         <= '0;
            frac_reg      <= '0;
            t1_reg        <= '0;
            lnv_reg       <= '0;
            q16_reg       <= '0;
            len_reg       <= '0;
            ulen_reg      <= '0;
            wp_reg        <= '0;
            sat_res_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_len_reg   <= '0;
            out_tot_reg   <= '0;
            out_sat_reg   <= 1'b0;
        end
        else begin
            if (psel && penable && pwrite && paddr[2] == REG_ALPHA) begin
                alpha_reg <= pwdata;
            end
            // a result loaded in S_TOTAL replaces the one leaving
            if (out_valid_reg && !out_stall && state_reg != S_TOTAL) begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (in_take) begin
                        v_reg[0]  <= pin_x;
                        v_reg[1]  <= (pin_x == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -pin_x;
                        v_reg[2]  <= pin_y;
                        v_reg[3]  <= (pin_y == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -pin_y;
                        w_reg     <= net_weight;
                        last_reg  <= last_pin;
                        first_reg <= first_net;
                        if (pin_x == 32'sh8000_0000 || pin_y == 32'sh8000_0000) begin
                            sat_flag_reg <= 1'b1;
                        end
                        dir_reg   <= '0;
                        state_reg <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    if (!net_open_reg) begin
                        // first pin of a net seeds max and sum
                        dir_max_reg[dir_reg] <= v_cur;
                        dir_sum_reg[dir_reg] <= SUM_ONE;
                        dir_reg <= dir_reg + 1'b1;
                        if (dir_reg == 2'd3) begin
                            net_open_reg <= 1'b1;
                            len_reg      <= '0;
                            state_reg    <= last_reg ? S_LN_START : S_IDLE;
                        end
                    end
                    else begin
                        gt_reg    <= fold_gt;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        t_reg     <= div_quo;
                        state_reg <= S_UMUL;
                    end
                end
                S_UMUL: begin
                    k_reg     <= mul_p[52:46];
                    f_reg     <= mul_p[45:14];
                    val_reg   <= 33'h1_0000_0000;
                    it_reg    <= '0;
                    state_reg <= S_EXP;
                end
                S_EXP: begin
                    if (f_reg[31]) begin
                        val_reg <= mul_p[64:32];
                    end
                    f_reg  <= f_reg << 1;
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == LAST_IT) begin
                        state_reg <= S_ESHIFT;
                    end
                end
                S_ESHIFT: begin
                    val_reg <= e_val;
                    if (gt_reg) begin
                        state_reg <= S_RESCALE;
                    end
                    else begin
                        add_reg   <= e_val >> SUM_INT_BITS;
                        base_reg  <= dir_sum_reg[dir_reg];
                        state_reg <= S_FADD;
                    end
                end
                S_RESCALE: begin
                    add_reg   <= mul_p[64:32];
                    base_reg  <= SUM_ONE;
                    state_reg <= S_FADD;
                end
                S_FADD: begin
                    if (fold_sum[33:32] != 2'b00) begin
                        dir_sum_reg[dir_reg] <= 32'hFFFF_FFFF;
                        sat_flag_reg         <= 1'b1;
                    end
                    else begin
                        dir_sum_reg[dir_reg] <= fold_sum[31:0];
                    end
                    if (gt_reg) begin
                        dir_max_reg[dir_reg] <= v_cur;
                    end
                    dir_reg <= dir_reg + 1'b1;
                    if (dir_reg == 2'd3) begin
                        net_open_reg <= 1'b1;
                        len_reg      <= '0;
                        state_reg    <= last_reg ? S_LN_START : S_IDLE;
                    end
                    else begin
                        state_reg <= S_FOLD;
                    end
                end
                S_LN_START: begin
                    len_reg <= len_reg + {{(LEN_ACC_W-32){max_cur[31]}}, max_cur};
                    if (dir_sum_reg[dir_reg] <= SUM_ONE) begin
                        // log of a sum at or below one counts as zero
                        dir_reg <= dir_reg + 1'b1;
                        if (dir_reg == 2'd3) begin
                            state_reg <= S_CLAMP;
                        end
                    end
                    else begin
                        m_reg     <= dir_sum_reg[dir_reg];
                        p_reg     <= 5'd31;
                        state_reg <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (m_reg[31]) begin
                        it_reg    <= '0;
                        frac_reg  <= '0;
                        state_reg <= S_SQ;
                    end
                    else begin
                        m_reg <= m_reg << 1;
                        p_reg <= p_reg - 1'b1;
                    end
                end
                S_SQ: begin
                    if (sq_val[32]) begin
                        m_reg    <= sq_val[32:1];
                        frac_reg <= {frac_reg[30:0], 1'b1};
                    end
                    else begin
                        m_reg    <= sq_val[31:0];
                        frac_reg <= {frac_reg[30:0], 1'b0};
                    end
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == LAST_IT) begin
                        state_reg <= S_LN_F;
                    end
                end
                S_LN_F: begin
                    t1_reg    <= mul_p[63:32];
                    state_reg <= S_LN_I;
                end
                S_LN_I: begin
                    lnv_reg   <= mul_p[37:0] + 38'(t1_reg);
                    state_reg <= S_LN_AL;
                end
                S_LN_AL: begin
                    t1_reg    <= mul_p[63:32];
                    state_reg <= S_LN_AH;
                end
                S_LN_AH: begin
                    q16_reg   <= 39'(mul_p[37:0]) + 39'(t1_reg);
                    state_reg <= S_LN_ADD;
                end
                S_LN_ADD: begin
                    len_reg <= len_reg + ln_term;
                    dir_reg <= dir_reg + 1'b1;
                    state_reg <= (dir_reg == 2'd3) ? S_CLAMP : S_LN_START;
                end
                S_CLAMP: begin
                    if (len_reg[LEN_ACC_W-1]) begin
                        ulen_reg    <= '0;
                        sat_res_reg <= 1'b1;
                    end
                    else if (len_reg[LEN_ACC_W-2:LEN_W] != '0) begin
                        ulen_reg    <= LEN_MAX;
                        sat_res_reg <= 1'b1;
                    end
                    else begin
                        ulen_reg    <= len_reg[LEN_W-1:0];
                        sat_res_reg <= sat_flag_reg;
                    end
                    state_reg <= S_W_LO;
                end
                S_W_LO: begin
                    wp_reg    <= TOT_W'(mul_p[35:0]);
                    state_reg <= S_W_HI;
                end
                S_W_HI: begin
                    wp_reg    <= wp_reg + (TOT_W'(mul_p[35:0]) << 20);
                    state_reg <= S_TOTAL;
                end
                S_TOTAL: begin
                    // hold until the output register is free
                    if (out_free) begin
                        if (tot_sum[TOT_W]) begin
                            total_reg   <= TOTAL_MAX;
                            out_tot_reg <= TOTAL_MAX;
                            out_sat_reg <= 1'b1;
                        end
                        else begin
                            total_reg   <= tot_sum[TOT_W-1:0];
                            out_tot_reg <= tot_sum[TOT_W-1:0];
                            out_sat_reg <= sat_res_reg;
                        end
                        out_len_reg   <= ulen_reg;
                        out_valid_reg <= 1'b1;
                        net_open_reg  <= 1'b0;
                        sat_flag_reg  <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign net_length     = out_len_reg;
    assign weighted_total = out_tot_reg;
    assign saturated      = out_sat_reg;
    assign pready         = 1'b1;
    assign prdata         = (paddr[2] == REG_ALPHA) ? alpha_reg : 32'h0;

    a_take_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_stall)
        else $error("block took a transaction but did not go busy");

    a_div_only_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished while sequencer was not waiting");

    a_close_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(net_open_reg) |-> out_valid_reg)
        else $error("net closed without a result");

    a_t_capped: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UMUL |-> t_reg <= T_CAP)
        else $error("exponent argument above cap");

endmodule

// ===== bench/lse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lse_checker: wirelength prediction and result compare
// Watches the configuration port and both channels, predicts the length and
// the weighted total of every closed net, and compares each result
// transaction, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module lse_checker
    import nlse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] pin_x,
    input  logic signed [31:0] pin_y,
    input  logic [15:0]        net_weight,
    input  logic               last_pin,
    input  logic               first_net,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [LEN_W-1:0]   net_length,
    input  logic [TOT_W-1:0]   weighted_total,
    input  logic               saturated,
    output int                 mismatches,
    output int                 results_owed
);

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [TOT_W-1:0] tot;
        logic             sat;
    } net_result_t;

    localparam logic [63:0] WORD_MASK = 64'hFFFF_FFFF;
    localparam logic [63:0] SUM_ONE   = 64'h1_0000;
    localparam logic [63:0] DECAY_CAP = 64'd32 << 16;

    net_result_t        net_results_due[$];
    logic [31:0]        alpha_q;
    logic signed [31:0] dir_peak [4];
    logic [31:0]        dir_sum [4];
    logic               net_started;
    logic [TOT_W-1:0]   running_total;
    logic               net_sat;
    logic [63:0]        root_q32 [32];

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] cand;
        res = '0;
        for (int b = 31; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            if (cand * cand <= n)
                res = cand;
        end
        return res;
    endfunction

    initial
    begin
        mismatches = 0;
        root_q32[0] = floor_sqrt(64'd1 << 63);
        for (int i = 1; i < 32; i++)
            root_q32[i] = floor_sqrt(root_q32[i-1] << 32);
    end

    // exp(-diff / alpha) in Q.32
    function automatic logic [63:0] decay(input logic [63:0] diff, input logic [63:0] a);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] val;
        logic [31:0] f;
        q = diff / a;
        r = diff % a;
        if (q > 64'd2)
            t = DECAY_CAP;
        else
        begin
            t = (q << 20) + ((r << 20) / a);
            if (t > DECAY_CAP)
                t = DECAY_CAP;
        end
        u = (t * 64'h5C55_1D95) >> 14;
        f = u[31:0];
        val = 64'd1 << 32;
        for (int i = 0; i < 16; i++)
            if (f[31-i])
                val = (val * root_q32[i]) >> 32;
        return (u >> 32) >= 64 ? 64'd0 : val >> (u >> 32);
    endfunction

    // alpha * ln(sum) in Q.12
    function automatic logic [63:0] alpha_log(input logic [31:0] sraw, input logic [63:0] a);
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] l2;
        logic [63:0] lnv;
        logic [63:0] q16;
        int          p;
        if (sraw <= 32'h1_0000)
            return 64'd0;
        p = 31;
        while (!sraw[p])
            p--;
        m = 64'(sraw) << (31 - p);
        frac = '0;
        for (int i = 1; i <= 16; i++)
        begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32))
            begin
                m = m >> 1;
                frac = frac | (64'd1 << (32 - i));
            end
        end
        l2 = (64'(p - 16) << 32) | frac;
        lnv = (l2 >> 32) * 64'hB172_17F8 + (((l2 & WORD_MASK) * 64'hB172_17F8) >> 32);
        q16 = a * (lnv >> 32) + ((a * (lnv & WORD_MASK)) >> 32);
        return q16 >> 4;
    endfunction

    task automatic fold_direction(input int d, input longint v, input logic [63:0] a);
        logic [63:0] s;
        logic [63:0] e;
        if (!net_started)
        begin
            dir_peak[d] = v[31:0];
            s = SUM_ONE;
        end
        else if (v <= longint'(dir_peak[d]))
            s = dir_sum[d] + (decay(64'(longint'(dir_peak[d]) - v), a) >> 16);
        else
        begin
            e = decay(64'(v - longint'(dir_peak[d])), a);
            s = ((dir_sum[d] * e) >> 32) + SUM_ONE;
            dir_peak[d] = v[31:0];
        end
        if (s > WORD_MASK)
        begin
            s = WORD_MASK;
            net_sat = 1'b1;
        end
        dir_sum[d] = s[31:0];
    endtask

    task automatic take_pin();
        logic [63:0] a;
        longint      dv [4];
        longint      len_acc;
        logic [63:0] ulen;
        logic [63:0] tot;
        logic        sat;
        net_result_t res;
        a = (alpha_q == 0) ? 64'd1 : 64'(alpha_q);
        dv[0] = longint'(pin_x);
        dv[2] = longint'(pin_y);
        for (int k = 0; k < 4; k += 2)
        begin
            if (dv[k] == -64'sd2147483648)
            begin
                dv[k+1] = 64'sd2147483647;
                net_sat = 1'b1;
            end
            else
                dv[k+1] = -dv[k];
        end
        for (int d = 0; d < 4; d++)
            fold_direction(d, dv[d], a);
        net_started = 1'b1;
        if (!last_pin)
            return;
        len_acc = 0;
        for (int d = 0; d < 4; d++)
            len_acc += longint'(dir_peak[d]) + longint'(alpha_log(dir_sum[d], a));
        sat = net_sat;
        if (len_acc < 0)
        begin
            ulen = '0;
            sat = 1'b1;
        end
        else if (64'(len_acc) > 64'hFF_FFFF_FFFF)
        begin
            ulen = 64'hFF_FFFF_FFFF;
            sat = 1'b1;
        end
        else
            ulen = 64'(len_acc);
        if (first_net)
            running_total = '0;
        tot = 64'(running_total) + ((64'(net_weight) * ulen) >> 8);
        if (tot > 64'hFF_FFFF_FFFF_FFFF)
        begin
            tot = 64'hFF_FFFF_FFFF_FFFF;
            sat = 1'b1;
        end
        running_total = tot[TOT_W-1:0];
        res.len = ulen[LEN_W-1:0];
        res.tot = running_total;
        res.sat = sat;
        net_results_due.push_back(res);
        net_started = 1'b0;
        net_sat = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_q = 32'd655360;
            for (int d = 0; d < 4; d++)
            begin
                dir_peak[d] = '0;
                dir_sum[d] = '0;
            end
            net_started = 1'b0;
            running_total = '0;
            net_sat = 1'b0;
            net_results_due.delete();
            results_owed <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == {REG_ALPHA, 2'b00})
                alpha_q = pwdata;
            if (in_valid && !in_stall)
                take_pin();
            if (out_valid && !out_stall)
            begin
                if (net_results_due.size() == 0)
                    report_mismatch("unexpected transaction", 64'(net_length), 64'd0);
                else
                begin
                    net_result_t want;
                    want = net_results_due.pop_front();
                    if (net_length !== want.len)
                        report_mismatch("net_length", 64'(net_length), 64'(want.len));
                    if (weighted_total !== want.tot)
                        report_mismatch("weighted_total", 64'(weighted_total),
                                        64'(want.tot));
                    if (saturated !== want.sat)
                        report_mismatch("saturated", 64'(saturated), 64'(want.sat));
                end
            end
            results_owed <= net_results_due.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: log-sum-exp wirelength regression
// Streams directed and random nets through the block under several alpha
// settings, with random idling on both channels; the checker predicts and
// compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import nlse_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int PIN_TARGET   = 1350;
    localparam int CALM_FROM    = 1200;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] pin_x = '0;
    logic signed [31:0] pin_y = '0;
    logic [15:0]        net_weight = '0;
    logic               last_pin = 1'b0;
    logic               first_net = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [LEN_W-1:0]   net_length;
    logic [TOT_W-1:0]   weighted_total;
    logic               saturated;

    int   mismatches;
    int   results_owed;
    int   pins_sent = 0;
    int   cycles = 0;
    int   stall_left = 0;
    logic calm = 1'b0;

    logic [31:0] alpha_steps [5] = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0};

    net_log_sum_exp_wirelength dut (.*);

    lse_checker checker_i (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready), .in_valid(in_valid),
        .in_stall(in_stall), .pin_x(pin_x), .pin_y(pin_y), .net_weight(net_weight),
        .last_pin(last_pin), .first_net(first_net), .out_valid(out_valid),
        .out_stall(out_stall), .net_length(net_length), .weighted_total(weighted_total),
        .saturated(saturated), .mismatches(mismatches), .results_owed(results_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result-side backpressure in random bursts
    always @(posedge clk)
    begin
        if (calm)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 19) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send_pin(input logic [31:0] x, input logic [31:0] y,
                            input logic [15:0] w, input logic lp, input logic fn);
        pin_x <= x;
        pin_y <= y;
        net_weight <= w;
        last_pin <= lp;
        first_net <= fn;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pins_sent++;
        if (pins_sent >= CALM_FROM)
            calm = 1'b1;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        // let the checker's owed count catch up with the last transaction
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
    endtask

    task automatic write_alpha(input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {REG_ALPHA, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [31:0] pick_coord(input logic [31:0] base);
        logic [31:0] spread;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default:
            begin
                spread = 32'd1 << $urandom_range(4, 22);
                return base + $urandom_range(0, spread) - (spread >> 1);
            end
        endcase
    endfunction

    task automatic send_net();
        int          pins;
        logic [31:0] bx;
        logic [31:0] by;
        pins = $urandom_range(1, 5);
        bx = $urandom;
        by = $urandom;
        for (int i = 0; i < pins; i++)
            send_pin(pick_coord(bx), pick_coord(by), 16'($urandom_range(0, 65535)),
                     i == pins - 1, $urandom_range(0, 7) == 0);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed nets at the reset alpha
        send_pin(32'h0, 32'h0, 16'h0100, 1'b1, 1'b1);
        send_pin(32'h8000_0000, 32'h8000_0000, 16'hFFFF, 1'b1, 1'b0);
        send_pin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, 1'b0);
        send_pin(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 1'b0, 1'b1);
        send_pin(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b1, 1'b0);
        for (int i = 0; i < 3; i++)
            send_pin(32'h0001_2345, 32'hFFFE_0000, 16'h0080, i == 2, 1'b0);
        send_pin(32'h0000_1000, 32'h0000_2000, 16'hFFFF, 1'b0, 1'b1);
        send_pin(32'h0000_3000, 32'hFFFF_F000, 16'h0001, 1'b0, 1'b0);
        send_pin(32'h0000_0800, 32'h0000_A000, 16'h5555, 1'b0, 1'b0);
        send_pin(32'hFFFF_C000, 32'h0000_0000, 16'hAAAA, 1'b1, 1'b1);
        send_pin(32'h5555_5555, 32'hAAAA_AAAA, 16'h1234, 1'b0, 1'b1);
        send_pin(32'hAAAA_AAAA, 32'h5555_5555, 16'hFEDC, 1'b1, 1'b0);
        while (pins_sent < 270)
            send_net();

        // alpha sweep: smallest, zero, largest, one, then random
        alpha_steps[4] = $urandom;
        for (int s = 0; s < 5; s++)
        begin
            drain();
            write_alpha(alpha_steps[s]);
            while (pins_sent < 270 + (s + 1) * (PIN_TARGET - 270) / 5)
                send_net();
        end

        drain();
        if (mismatches == 0 && results_owed == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/nlse_pkg.sv
rtl/nlse_div.sv
rtl/net_log_sum_exp_wirelength.sv
bench/lse_checker.sv
bench/testbench.sv
